/* rtl/pll_divider_search_defines.svh */
// ----------------------------------------------------------------------------
// PLL divider search: assertion macros
// Shared assertion macros; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked concurrent check of one property
`define PDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that one condition is followed by another on the next cycle
`define PDS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define PDS_ASSERT(lbl, clk, rst, prop, msg)
`define PDS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

/* rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// PLL divider search package
// Field widths, register indexes, reset values, unit control structs and the
// register word packing shared by the block's modules.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Field widths
  localparam int FREQ_W = 28;
  localparam int REF_W  = 26;
  localparam int N_W    = 12;
  localparam int DIV_W  = 7;
  localparam int CFG_W  = 28;
  localparam int ASAT_W = 13;

  // Search limits
  localparam int N_MAX   = 4095;
  localparam int DIV_MAX = 127;
  localparam logic [ASAT_W-1:0] A_SAT = 13'h1000;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REF_FREQ = 2'd0;
  localparam cfg_idx_t CFG_MIN_OUT  = 2'd1;
  localparam cfg_idx_t CFG_MAX_OUT  = 2'd2;
  localparam cfg_idx_t CFG_MAX_VCO  = 2'd3;

  // Register reset values
  localparam logic [REF_W-1:0]  RST_REF_FREQ = 26'd27000000;
  localparam logic [FREQ_W-1:0] RST_MIN_OUT  = 28'd1000000;
  localparam logic [FREQ_W-1:0] RST_MAX_OUT  = 28'd230000000;
  localparam logic [FREQ_W-1:0] RST_MAX_VCO  = 28'd230000000;

  // VCO band thresholds
  localparam logic [FREQ_W-1:0] BAND1_HZ = 28'd125000000;
  localparam logic [FREQ_W-1:0] BAND2_HZ = 28'd150000000;
  localparam logic [FREQ_W-1:0] BAND3_HZ = 28'd175000000;

  // Settings given to a rejected request
  localparam logic [N_W-1:0] REJ_N = 12'd4;
  localparam logic [2:0]     REJ_P = 3'd2;
  localparam logic [5:0]     REJ_Q = 6'd16;

  typedef struct packed {
    logic [FREQ_W-1:0] out_freq_hz;
  } req_item_t;

  typedef struct packed {
    logic [DIV_W-1:0] post_div;
    logic [N_W-1:0]   feedback_n;
    logic [2:0]       shift_p;
    logic [5:0]       quotient_q;
    logic [8:0]       remainder_r;
    logic [1:0]       vco_band;
    logic [31:0]      pll_word;
    logic             out_of_range;
  } rsp_item_t;

  // Shared divider control and status
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
    logic [REF_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FREQ_W-1:0] quotient;
    logic [REF_W-1:0]  remainder;
  } div_rsp_t;

  // Candidate search control and status
  typedef struct packed {
    logic              start;
    logic [ASAT_W-1:0] a_sat;
    logic [REF_W-1:0]  b;
    logic [REF_W-1:0]  fref;
  } srch_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } srch_stat_t;

  function automatic logic [31:0] pack_word(input logic [N_W-1:0] n, input logic [8:0] r,
                                            input logic [5:0] q, input logic [2:0] p,
                                            input logic [1:0] band);
    return {n, r, q, p, band};
  endfunction

endpackage

/* rtl/pds_stream_if.sv */
// ----------------------------------------------------------------------------
// PLL divider search stream channel
// Valid/ready channel carrying one word of any packed payload type.
// ----------------------------------------------------------------------------
interface pds_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/pds_div.sv */
// ----------------------------------------------------------------------------
// PLL divider search: shared divider
// Restoring divider, one quotient bit per cycle; used for fvco/fref and for
// the Q/R split of N*2^P by M.
// ----------------------------------------------------------------------------
`include "pll_divider_search_defines.svh"

module pds_div (
  input  logic               clk,
  input  logic               rst,
  input  pds_pkg::div_req_t  ctl,
  output pds_pkg::div_rsp_t  st
);
  import pds_pkg::*;

  localparam int CW = $clog2(FREQ_W + 1);
  localparam logic [CW-1:0] STEPS = CW'(FREQ_W);
  localparam logic [CW-1:0] LAST  = CW'(1);

  logic [CW-1:0]     cnt;
  logic [FREQ_W-1:0] quo;
  logic [REF_W-1:0]  rem;
  logic [REF_W-1:0]  dvs;
  logic              done_q;

  logic [REF_W:0] shifted;
  logic [REF_W:0] diff;
  logic           fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem, quo[FREQ_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  // Load on start, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl.start) begin
        quo <= ctl.dividend;
        rem <= '0;
        dvs <= ctl.divisor;
        cnt <= STEPS;
      end else if (cnt != '0) begin
        rem <= fits ? diff[REF_W-1:0] : shifted[REF_W-1:0];
        quo <= {quo[FREQ_W-2:0], fits};
        cnt <= cnt - LAST;
        if (cnt == LAST) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign st.busy      = (cnt != '0);
  assign st.done      = done_q;
  assign st.quotient  = quo;
  assign st.remainder = rem;

  `PDS_ASSERT_NEXT(a_div_start, clk, rst, ctl.start, (cnt != '0), "divider did not start")
  `PDS_ASSERT(a_div_rem, clk, rst, done_q |-> (rem < dvs), "remainder not below divisor")

endmodule

/* rtl/pds_search.sv */
// ----------------------------------------------------------------------------
// PLL divider search: N/M candidate search
// Walks M upward, tracking floor(fvco*M/fref) and its remainder
// incrementally, and checks N0 and N0+1 on alternate cycles against the best
// so far through one cross-product comparator.
// ----------------------------------------------------------------------------
`include "pll_divider_search_defines.svh"

module pds_search #(
  parameter int M_MAX = 511
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pds_pkg::srch_req_t                  req,
  output pds_pkg::srch_stat_t                 stat,
  output logic [pds_pkg::N_W-1:0]             best_n,
  output logic [$clog2(M_MAX + 1)-1:0]        best_m
);
  import pds_pkg::*;

  localparam int MW = $clog2(M_MAX + 1);
  localparam int PW = REF_W + MW;
  localparam logic [MW-1:0] M_ONE  = MW'(1);
  localparam logic [MW-1:0] M_LAST = MW'(M_MAX);
  localparam logic [ASAT_W:0] N_LIM = (ASAT_W + 1)'(N_MAX);

  logic              run;
  logic              phase;
  logic              found;
  logic              done_q;
  logic [MW-1:0]     m;
  logic [N_W-1:0]    n0;
  logic [REF_W-1:0]  rem;
  logic [ASAT_W-1:0] a_q;
  logic [REF_W-1:0]  b_q;
  logic [REF_W-1:0]  fref_q;
  logic [REF_W-1:0]  best_e;

  logic [N_W:0]      cand_n;
  logic [REF_W-1:0]  cand_e;
  logic              cand_ok;
  logic [PW-1:0]     lhs;
  logic [PW-1:0]     rhs;
  logic              better;
  logic [REF_W:0]    sum_r;
  logic              carry;
  logic [REF_W-1:0]  rem_adv;
  logic [ASAT_W:0]   n_adv;

  // Candidate of this cycle: N0 with error rem, or N0+1 with error fref-rem
  assign cand_n  = phase ? ({1'b0, n0} + (N_W + 1)'(1)) : {1'b0, n0};
  assign cand_e  = phase ? (fref_q - rem) : rem;
  assign cand_ok = phase ? ((ASAT_W + 1)'(cand_n) <= N_LIM) : (n0 != '0);

  // Compare e/m against best_e/best_m as cross products
  assign lhs    = PW'(cand_e) * PW'(best_m);
  assign rhs    = PW'(best_e) * PW'(m);
  assign better = !found || (lhs < rhs);

  // Step to the next M: add fvco = A*fref + B
  assign sum_r   = {1'b0, rem} + {1'b0, b_q};
  assign carry   = sum_r >= {1'b0, fref_q};
  assign rem_adv = carry ? REF_W'(sum_r - {1'b0, fref_q}) : sum_r[REF_W-1:0];
  assign n_adv   = (ASAT_W + 1)'(n0) + (ASAT_W + 1)'(a_q) + (ASAT_W + 1)'(carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      phase  <= 1'b0;
      found  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        // Load the walk at M = 1; skip all when N0 already exceeds the limit
        found  <= 1'b0;
        phase  <= 1'b0;
        m      <= M_ONE;
        n0     <= req.a_sat[N_W-1:0];
        rem    <= req.b;
        a_q    <= req.a_sat;
        b_q    <= req.b;
        fref_q <= req.fref;
        if ({1'b0, req.a_sat} > N_LIM) begin
          run    <= 1'b0;
          done_q <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        // Keep the first best candidate
        if (cand_ok && better) begin
          found  <= 1'b1;
          best_n <= cand_n[N_W-1:0];
          best_m <= m;
          best_e <= cand_e;
        end
        if (!phase) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          // N0 only grows with M: stop once it leaves the range
          if (m == M_LAST || n_adv > N_LIM) begin
            run    <= 1'b0;
            done_q <= 1'b1;
          end else begin
            m   <= m + M_ONE;
            n0  <= n_adv[N_W-1:0];
            rem <= rem_adv;
          end
        end
      end
    end
  end

  assign stat.busy  = run;
  assign stat.done  = done_q;
  assign stat.found = found;

  `PDS_ASSERT(a_best_sane, clk, rst, found |-> (best_m != '0 && best_n != '0 && (ASAT_W + 1)'(best_n) <= N_LIM), "best candidate out of range")
  `PDS_ASSERT(a_m_range, clk, rst, run |-> (m != '0 && m <= M_LAST), "M counter out of range")

endmodule

/* rtl/pll_divider_search.sv */
// ----------------------------------------------------------------------------
// PLL divider search: top level
// Turns a wanted output frequency into post-divider, N, P, Q, R, VCO band and
// the packed PLL register word.
// ----------------------------------------------------------------------------
// One request at a time: req.ready is high only while the block is idle. A
// request outside the output window returns fixed settings through the
// finish state. Any other request walks the post-divider down from 127 one
// step a cycle, divides fvco by fref on the shared restoring divider,
// searches M = 1..M_MAX in the cross-product comparator, checking N0 and
// N0+1 for each M and stopping early once N runs past its limit, then
// splits N*2^P by M on the same divider.
// Configuration writes take effect at once and belong in idle periods.
`include "pll_divider_search_defines.svh"

module pll_divider_search #(
  parameter int M_MAX = 511
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  pds_pkg::cfg_idx_t            cfg_idx,
  input  logic [pds_pkg::CFG_W-1:0]    cfg_wdata,
  pds_stream_if.sink                   req,
  pds_stream_if.source                 rsp
);
  import pds_pkg::*;

  localparam int MW = $clog2(M_MAX + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PDIV   = 3'd1;
  localparam logic [2:0] ST_DIV1   = 3'd2;
  localparam logic [2:0] ST_SRCH   = 3'd3;
  localparam logic [2:0] ST_PQ     = 3'd4;
  localparam logic [2:0] ST_DIV2   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  localparam int PRD_W = FREQ_W + DIV_W;
  localparam logic [DIV_W-1:0] K_ONE = DIV_W'(1);

  // Configuration registers
  logic [REF_W-1:0]  ref_freq_hz;
  logic [FREQ_W-1:0] min_out_hz;
  logic [FREQ_W-1:0] max_out_hz;
  logic [FREQ_W-1:0] max_vco_hz;

  logic [2:0]        state;
  logic [FREQ_W-1:0] fout;
  logic [PRD_W-1:0]  prod;
  logic [DIV_W-1:0]  k;
  logic [DIV_W-1:0]  post_div;
  logic [FREQ_W-1:0] fvco;
  logic [N_W-1:0]    n_q;
  logic [MW-1:0]     m_q;
  logic [2:0]        p_q;
  rsp_item_t         res;
  rsp_item_t         rsp_data;
  logic              rsp_valid;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  srch_req_t  srch_req;
  srch_stat_t srch_st;
  logic [N_W-1:0] srch_n;
  logic [MW-1:0]  srch_m;

  logic [FREQ_W-1:0] fin;
  logic              reject;
  logic [REF_W-1:0]  fref_eff;
  logic [ASAT_W-1:0] a_sat;
  logic [15:0]       m16;
  logic [15:0]       n16;
  logic [2:0]        shift_cnt;
  logic [2:0]        p_calc;
  logic [15:0]       nd;
  logic [1:0]        band;
  logic [5:0]        q_fld;
  logic [8:0]        r_fld;

  pds_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_req),
    .st  (div_rsp)
  );

  pds_search #(
    .M_MAX (M_MAX)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .req    (srch_req),
    .stat   (srch_st),
    .best_n (srch_n),
    .best_m (srch_m)
  );

  // Window check on the incoming word
  assign fin    = req.data.out_freq_hz;
  assign reject = (fin <= min_out_hz) || (fin > max_out_hz);

  // A zero reference acts as one
  assign fref_eff = (ref_freq_hz == '0) ? REF_W'(1) : ref_freq_hz;

  // Clamp the integer part of fvco/fref to just past the N limit
  assign a_sat = (div_rsp.quotient > FREQ_W'(A_SAT)) ? A_SAT : div_rsp.quotient[ASAT_W-1:0];

  // P = 4 - floor(log2(N/M)), clamped: count the doublings of M that fit
  assign m16       = 16'(m_q);
  assign n16       = 16'(n_q);
  assign shift_cnt = 3'((m16 << 1) <= n16) + 3'((m16 << 2) <= n16) +
                     3'((m16 << 3) <= n16) + 3'((m16 << 4) <= n16);
  assign p_calc    = 3'd4 - shift_cnt;
  assign nd        = n16 << p_calc;

  // VCO band and truncated Q/R fields
  assign band  = (fvco < BAND1_HZ) ? 2'd0 :
                 (fvco < BAND2_HZ) ? 2'd1 :
                 (fvco < BAND3_HZ) ? 2'd2 : 2'd3;
  assign q_fld = div_rsp.quotient[5:0];
  assign r_fld = div_rsp.remainder[8:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rsp_valid      <= 1'b0;
      div_req.start  <= 1'b0;
      srch_req.start <= 1'b0;
      ref_freq_hz    <= RST_REF_FREQ;
      min_out_hz     <= RST_MIN_OUT;
      max_out_hz     <= RST_MAX_OUT;
      max_vco_hz     <= RST_MAX_VCO;
    end else begin
      div_req.start  <= 1'b0;
      srch_req.start <= 1'b0;

      // Register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_REF_FREQ: ref_freq_hz <= cfg_wdata[REF_W-1:0];
          CFG_MIN_OUT:  min_out_hz  <= cfg_wdata[FREQ_W-1:0];
          CFG_MAX_OUT:  max_out_hz  <= cfg_wdata[FREQ_W-1:0];
          CFG_MAX_VCO:  max_vco_hz  <= cfg_wdata[FREQ_W-1:0];
          default: ;
        endcase
      end

      // Drop the output word once taken
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            fout <= fin;
            if (reject) begin
              res.post_div     <= '0;
              res.feedback_n   <= REJ_N;
              res.shift_p      <= REJ_P;
              res.quotient_q   <= REJ_Q;
              res.remainder_r  <= '0;
              res.vco_band     <= '0;
              res.pll_word     <= pack_word(REJ_N, 9'd0, REJ_Q, REJ_P, 2'd0);
              res.out_of_range <= 1'b1;
              state            <= ST_FINISH;
            end else begin
              prod  <= PRD_W'(fin) * PRD_W'(DIV_MAX);
              k     <= DIV_W'(DIV_MAX);
              state <= ST_PDIV;
            end
          end
        end

        // Walk the post-divider down until fout*k fits under the VCO limit or k is one
        ST_PDIV: begin
          if (prod <= PRD_W'(max_vco_hz) || k == K_ONE) begin
            if (prod <= PRD_W'(max_vco_hz)) begin
              post_div         <= k;
              fvco             <= prod[FREQ_W-1:0];
              div_req.dividend <= prod[FREQ_W-1:0];
            end else begin
              post_div         <= '0;
              fvco             <= fout;
              div_req.dividend <= fout;
            end
            div_req.start   <= 1'b1;
            div_req.divisor <= fref_eff;
            state           <= ST_DIV1;
          end else begin
            prod <= prod - PRD_W'(fout);
            k    <= k - K_ONE;
          end
        end

        // fvco = A*fref + B, then start the candidate walk
        ST_DIV1: begin
          if (div_rsp.done) begin
            srch_req.start <= 1'b1;
            srch_req.a_sat <= a_sat;
            srch_req.b     <= div_rsp.remainder;
            srch_req.fref  <= fref_eff;
            state          <= ST_SRCH;
          end
        end

        // Saturate to N_MAX/1 when nothing was in range
        ST_SRCH: begin
          if (srch_st.done) begin
            n_q   <= srch_st.found ? srch_n : N_W'(N_MAX);
            m_q   <= srch_st.found ? srch_m : MW'(1);
            state <= ST_PQ;
          end
        end

        ST_PQ: begin
          p_q              <= p_calc;
          div_req.start    <= 1'b1;
          div_req.dividend <= FREQ_W'(nd);
          div_req.divisor  <= REF_W'(m_q);
          state            <= ST_DIV2;
        end

        ST_DIV2: begin
          if (div_rsp.done) begin
            res.post_div     <= post_div;
            res.feedback_n   <= n_q;
            res.shift_p      <= p_q;
            res.quotient_q   <= q_fld;
            res.remainder_r  <= r_fld;
            res.vco_band     <= band;
            res.pll_word     <= pack_word(n_q, r_fld, q_fld, p_q, band);
            res.out_of_range <= 1'b0;
            state            <= ST_FINISH;
          end
        end

        // Hold until the output register is free
        ST_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_data  <= res;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  `PDS_ASSERT(a_idle_units, clk, rst, (state == ST_IDLE) |-> (!div_rsp.busy && !srch_st.busy), "unit busy while idle")
  `PDS_ASSERT(a_reject_fixed, clk, rst, (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.post_div == '0 && rsp_data.feedback_n == REJ_N), "bad rejected word")
  `PDS_ASSERT(a_shift_range, clk, rst, (rsp_valid && !rsp_data.out_of_range) |-> (rsp_data.shift_p <= 3'd4 && rsp_data.feedback_n != '0), "bad result word")

endmodule
